// ----- sv/sitad_pkg.sv -----
// shared types and constants for the signed integer to decimal text converter
package sitad_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int NUM_DIGITS  = 5;
    localparam int IDX_WIDTH   = 3;
    localparam int DIGIT_WIDTH = 4;
    localparam int CHAR_WIDTH  = 8;

    // x / 10 == (x * RECIP_TEN) >> RECIP_SHIFT for every 16-bit x
    localparam logic [VALUE_WIDTH-1:0] RECIP_TEN   = 16'd52429;
    localparam int                     RECIP_SHIFT = 19;
    localparam int                     PROD_WIDTH  = 2 * VALUE_WIDTH;
    localparam int                     QUO_WIDTH   = PROD_WIDTH - RECIP_SHIFT;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;

    typedef logic [NUM_DIGITS-1:0][DIGIT_WIDTH-1:0] sitad_digits_t;

    typedef struct packed {
        logic                   neg;
        logic [VALUE_WIDTH-1:0] quo;
        sitad_digits_t          digits;
    } sitad_item_t;

endpackage

// ----- sv/sitad_digit_stage.sv -----
// one pipeline stage that peels off the lowest decimal digit
module sitad_digit_stage
    import sitad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_ready,
    input  sitad_item_t up_item,
    output logic        dn_valid,
    input  logic        dn_ready,
    output sitad_item_t dn_item
);

    logic                   valid_reg;
    sitad_item_t            item_reg;
    sitad_item_t            item_next;
    logic [PROD_WIDTH-1:0]  prod;
    logic [VALUE_WIDTH-1:0] quo;
    logic [VALUE_WIDTH-1:0] quo_times_ten;
    logic [VALUE_WIDTH-1:0] rem;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

    always_comb
    begin
        prod          = PROD_WIDTH'(up_item.quo) * PROD_WIDTH'(RECIP_TEN);
        quo           = VALUE_WIDTH'(prod[PROD_WIDTH-1:RECIP_SHIFT]);
        quo_times_ten = (quo << 3) + (quo << 1);
        rem           = up_item.quo - quo_times_ten;
        item_next.neg    = up_item.neg;
        item_next.quo    = quo;
        // newest digit enters at the top, so the ones digit ends at index 0
        item_next.digits = {rem[DIGIT_WIDTH-1:0], up_item.digits[NUM_DIGITS-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- sv/sitad_serializer.sv -----
// emits the sign and the significant digits, one character at a time
module sitad_serializer
    import sitad_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  sitad_item_t           up_item,
    output logic                  char_valid,
    input  logic                  char_stall,
    output logic [CHAR_WIDTH-1:0] character,
    output logic                  is_last
);

    logic                 busy_reg;
    logic                 sign_reg;
    logic [IDX_WIDTH-1:0] idx_reg;
    sitad_digits_t        digits_reg;
    logic [IDX_WIDTH-1:0] idx_start;
    logic                 take;
    logic                 load;

    always_comb
    begin
        idx_start = '0;
        for (int i = 1; i < NUM_DIGITS; i++)
        begin
            if (up_item.digits[i] != '0)
            begin
                idx_start = IDX_WIDTH'(i);
            end
        end
    end

    assign char_valid = busy_reg;
    assign is_last    = !sign_reg && (idx_reg == '0);
    assign character  = sign_reg ? CHAR_MINUS
                      : (CHAR_ZERO | CHAR_WIDTH'(digits_reg[idx_reg[IDX_WIDTH-1:0]]));
    assign take       = busy_reg && !char_stall;
    assign up_ready   = !busy_reg || (take && is_last);
    assign load       = up_ready && up_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sign_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            sign_reg <= up_item.neg;
            idx_reg  <= idx_start;
        end
        else if (take)
        begin
            if (sign_reg)
            begin
                sign_reg <= 1'b0;
            end
            else if (idx_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            digits_reg <= up_item.digits;
        end
    end

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg < IDX_WIDTH'(NUM_DIGITS)))
        else $error("digit index out of range");

    a_no_early_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !is_last) |=> busy_reg)
        else $error("number ended before its last character");

    a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
        (load && up_item.neg) |=> (char_valid && character == CHAR_MINUS && !is_last))
        else $error("negative number does not start with minus");
`endif

endmodule

// ----- sv/signed_int_to_ascii_decimal.sv -----
// top level of the signed 16-bit integer to decimal ascii text converter
//
// Each request carries a signed 16-bit value; the block returns its decimal
// text most significant character first, a leading '-' for negative values,
// no leading zeros, a single '0' for zero, and is_last on the final character.
// -32768 prints correctly. A value passes a sign stage and five digit stages
// (one multiply by the reciprocal of ten each) and the serializer's register
// before its first character is offered. The output serializer sends one
// character per cycle while char_stall is low; a number is one to six
// characters long, and the pipeline keeps taking requests behind it until
// its stages fill.
module signed_int_to_ascii_decimal
    import sitad_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   char_valid,
    input  logic                   char_stall,
    output logic [CHAR_WIDTH-1:0]  character,
    output logic                   is_last
);

    logic                      sign_valid_reg;
    sitad_item_t               sign_item_reg;
    sitad_item_t               sign_item_next;
    logic                      sign_ready;
    logic [NUM_DIGITS:0]       stg_valid;
    logic [NUM_DIGITS:0]       stg_ready;
    sitad_item_t [NUM_DIGITS:0] stg_item;

    // magnitude formed unsigned so the most negative value works
    always_comb
    begin
        sign_item_next.neg    = value[VALUE_WIDTH-1];
        sign_item_next.quo    = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
        sign_item_next.digits = '0;
    end

    assign sign_ready = !sign_valid_reg || stg_ready[0];
    assign req_stall  = !sign_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sign_valid_reg <= 1'b0;
        end
        else if (sign_ready)
        begin
            sign_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sign_ready && req_valid)
        begin
            sign_item_reg <= sign_item_next;
        end
    end

    assign stg_valid[0] = sign_valid_reg;
    assign stg_item[0]  = sign_item_reg;

    for (genvar g = 0; g < NUM_DIGITS; g++)
    begin : g_digit
        sitad_digit_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stg_valid[g]),
            .up_ready (stg_ready[g]),
            .up_item  (stg_item[g]),
            .dn_valid (stg_valid[g+1]),
            .dn_ready (stg_ready[g+1]),
            .dn_item  (stg_item[g+1])
        );
    end

    sitad_serializer u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (stg_valid[NUM_DIGITS]),
        .up_ready   (stg_ready[NUM_DIGITS]),
        .up_item    (stg_item[NUM_DIGITS]),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .character  (character),
        .is_last    (is_last)
    );

endmodule

// ----- tb/tb.sv -----
// testbench for the signed integer to decimal ascii text converter
module tb;
    import sitad_pkg::*;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] code;
        logic                  last;
    } text_char_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    logic [VALUE_WIDTH-1:0] value = '0;
    logic                   char_valid;
    logic                   char_stall = 1'b0;
    logic [CHAR_WIDTH-1:0]  character;
    logic                   is_last;

    logic [VALUE_WIDTH-1:0] pending_values[$];
    text_char_t             expected_chars[$];

    int  queued_total     = 0;
    int  accepted_count   = 0;
    int  chars_seen       = 0;
    int  negative_count   = 0;
    int  full_width_count = 0;
    int  mismatch_count   = 0;
    int  send_gap_left    = 0;
    int  send_quiet_left  = 0;
    int  recv_stall_left  = 0;
    int  recv_quiet_left  = 0;
    logic hold_off        = 1'b0;

    localparam int NUM_DIRECTED = 22;
    localparam int NUM_RANDOM   = 400;
    localparam int HOLD_CYCLES  = 150;

    logic [VALUE_WIDTH-1:0] directed_values[NUM_DIRECTED] = '{
        16'd0, 16'd1, 16'hFFFF, 16'd9, 16'd10, -16'sd10, 16'd99, 16'd100,
        16'd999, 16'd1000, 16'd9999, 16'd10000, 16'd32767, 16'h8000,
        16'h8001, -16'sd9, 16'd12345, -16'sd12345, 16'h5555, 16'hAAAA,
        16'd30000, -16'sd1000
    };

    signed_int_to_ascii_decimal DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .value      (value),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .character  (character),
        .is_last    (is_last)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s at %0t: got 0x%0h, want 0x%0h", what, $time, got, want);
        mismatch_count++;
    endtask

    // mostly short gaps, a few long ones, and stretches with none
    function automatic int idle_length(inout int quiet_left);
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            quiet_left = $urandom_range(10, 40);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void predict_text(logic [VALUE_WIDTH-1:0] v);
        logic                   neg;
        logic [VALUE_WIDTH-1:0] mag;
        logic [3:0]             digit_buf[NUM_DIGITS];
        int                     nd;
        text_char_t             c;
        neg = v[VALUE_WIDTH-1];
        mag = neg ? (~v + 1'b1) : v;
        nd  = 0;
        do
        begin
            digit_buf[nd] = 4'(mag % 10);
            mag = mag / 10;
            nd++;
        end
        while (mag != 0);
        if (neg)
        begin
            c.code = CHAR_MINUS;
            c.last = 1'b0;
            expected_chars.push_back(c);
            negative_count++;
        end
        for (int k = nd - 1; k >= 0; k--)
        begin
            c.code = CHAR_ZERO + CHAR_WIDTH'(digit_buf[k]);
            c.last = (k == 0);
            expected_chars.push_back(c);
        end
        if (nd + int'(neg) == NUM_DIGITS + 1)
            full_width_count++;
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] random_value();
        int mag;
        int ndig;
        logic neg;
        if ($urandom_range(0, 9) < 3)
            return VALUE_WIDTH'($urandom);
        ndig = $urandom_range(1, NUM_DIGITS);
        case (ndig)
            1: mag = $urandom_range(0, 9);
            2: mag = $urandom_range(10, 99);
            3: mag = $urandom_range(100, 999);
            4: mag = $urandom_range(1000, 9999);
            default: mag = $urandom_range(10000, 32768);
        endcase
        neg = 1'($urandom_range(0, 1));
        if (mag == 32768)
            neg = 1'b1;
        return neg ? VALUE_WIDTH'(-mag) : VALUE_WIDTH'(mag);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : driver
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            value     <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                predict_text(value);
                accepted_count++;
            end
            if (!req_valid || !req_stall)
            begin
                if (send_gap_left > 0)
                begin
                    send_gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_values.size() != 0)
                begin
                    req_valid     <= 1'b1;
                    value         <= pending_values.pop_front();
                    send_gap_left = idle_length(send_quiet_left);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        text_char_t want;
        logic       stall_now;
        if (!rst_n)
            char_stall <= 1'b0;
        else
        begin
            if (char_valid && !char_stall)
            begin
                chars_seen++;
                if (expected_chars.size() == 0)
                    report_mismatch("character with no request pending", character, 0);
                else
                begin
                    want = expected_chars.pop_front();
                    if (character !== want.code)
                        report_mismatch("character", character, want.code);
                    if (is_last !== want.last)
                        report_mismatch("is_last", is_last, want.last);
                end
            end
            if (recv_stall_left > 0)
            begin
                recv_stall_left--;
                stall_now = 1'b1;
            end
            else
            begin
                recv_stall_left = idle_length(recv_quiet_left);
                stall_now = (recv_stall_left > 0);
                if (stall_now)
                    recv_stall_left--;
            end
            char_stall <= stall_now || hold_off;
        end
    end

    // long receiver hold-off while requests keep coming
    initial
    begin : receiver_hold
        wait (accepted_count >= NUM_DIRECTED + 60);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin : run_limit
        #10_000_000;
        $display("run timed out at %0t", $time);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_values[k])
            pending_values.push_back(directed_values[k]);
        queued_total = NUM_DIRECTED;
        while (accepted_count != queued_total || expected_chars.size() != 0)
            @(posedge clk);

        // sender has paused until the pipeline drained, now random requests
        for (int k = 0; k < NUM_RANDOM; k++)
            pending_values.push_back(random_value());
        queued_total += NUM_RANDOM;
        while (accepted_count != queued_total || expected_chars.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("converted %0d numbers (%0d negative, %0d six characters long), %0d chars checked",
                 accepted_count, negative_count, full_width_count, chars_seen);
        $display("includes a full drain after the directed part and a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
